// File: src/pfs_pkg.sv
// Types, character codes and constants shared across the format streamer.
package pfs_pkg;

	localparam int MAX_DIGITS_DEF = 16;
	localparam int PADDR_W = 3;

	localparam logic [0:0] REG_SIZE    = 1'b0;
	localparam logic [0:0] REG_PRESENT = 1'b1;

	localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_X     = 8'h78;

	typedef struct packed {
		logic [7:0]  fmt_byte;
		logic [31:0] arg_value;
	} pfs_in_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [31:0] position;
		logic        stored;
		logic        is_terminator;
		logic [31:0] total_length;
		logic        last;
	} pfs_out_t;

	typedef struct packed {
		logic [31:0] size;
		logic        present;
	} pfs_cfg_t;

	typedef struct packed {
		logic        start;
		logic        hex;
		logic        upper;
		logic        pop;
		logic [31:0] value;
	} digit_ctrl_t;

	typedef struct packed {
		logic       busy;
		logic       one;
		logic [7:0] digit;
	} digit_stat_t;

endpackage

// File: src/pfs_regs.sv
// Configuration registers behind the APB-style port.
module pfs_regs import pfs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output pfs_cfg_t           cfg
);

	logic [31:0] size_q;
	logic        present_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign cfg.size = size_q;
	assign cfg.present = present_q;

	always_comb begin
		unique case (paddr[2])
			REG_SIZE:    prdata = size_q;
			REG_PRESENT: prdata = {31'd0, present_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 32'hFFFF_FFFF;
			present_q <= 1'b1;
		end else if (wr) begin
			unique case (paddr[2])
				REG_SIZE:    size_q <= pwdata;
				REG_PRESENT: present_q <= pwdata[0];
			endcase
		end
	end

endmodule

// File: src/pfs_digit.sv
// Shared digit unit: one divide step per cycle into a scratch store, read back in reverse.
module pfs_digit import pfs_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  digit_ctrl_t ctrl,
	output digit_stat_t stat
);

	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);

	logic [7:0]    mem [MAX_DIGITS];
	logic [7:0]    rdata_q;
	logic [31:0]   val_q;
	logic          hex_q;
	logic          upper_q;
	logic          div_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_d;
	logic [CW-1:0] raddr;
	logic [63:0]   prod;
	logic [31:0]   quot;
	logic [3:0]    q10;
	logic [3:0]    dig;
	logic [7:0]    ch;
	logic          full;
	logic          we;

	always_comb begin
		prod = {32'd0, val_q} * {32'd0, DIV10_RECIP};
		quot = hex_q ? {4'd0, val_q[31:4]} : {3'd0, prod[63:35]};
		q10 = {quot[0], 3'b000} + {quot[2:0], 1'b0};
		dig = hex_q ? val_q[3:0] : val_q[3:0] - q10;
		if (dig < 4'd10) begin
			ch = CH_ZERO + {4'd0, dig};
		end else begin
			ch = (upper_q ? CH_UA : CH_LA) + {4'd0, dig} - 8'd10;
		end
		full = cnt_q == CW'(MAX_DIGITS);
		we = div_q && !full;
		priority if (ctrl.start) begin
			cnt_d = '0;
		end else if (we) begin
			cnt_d = cnt_q + CW'(1);
		end else if (ctrl.pop) begin
			cnt_d = cnt_q - CW'(1);
		end else begin
			cnt_d = cnt_q;
		end
		raddr = cnt_d - CW'(1);
	end

	assign stat.busy = div_q;
	assign stat.one = cnt_q == CW'(1);
	assign stat.digit = rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[cnt_q[AW-1:0]] <= ch;
		end
		rdata_q <= mem[raddr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			val_q <= ctrl.value;
			hex_q <= ctrl.hex;
			upper_q <= ctrl.upper;
		end else if (div_q) begin
			val_q <= quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
			if (ctrl.start) begin
				div_q <= 1'b1;
			end else if (div_q && quot == 32'd0) begin
				div_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/printf_format_stream.sv
// Streaming printf-style formatter: sequencer, output register and top-level wiring.
//
//  channel  direction  handshake              payload
//  fmt      in         fmt_valid / fmt_ready  pfs_in_t  (fmt_byte, arg_value)
//  res      out        res_valid / res_ready  pfs_out_t (one request per character)
//  apb      in         psel/penable/pready    buffer_size, buffer_present
//
// Plain bytes and the terminator go straight to the output register. A numeric conversion
// runs in the divide unit (reciprocal multiply by ten, or a four-bit shift), then the digits
// come back one a cycle from the scratch read port while the res channel is not stalled.
// Reset clears the sequencer, pending percent and count; the scratch needs no clearing.
// A stalled res channel holds the sequencer wherever it would emit; fmt_ready stays low until the item is done.
module printf_format_stream import pfs_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fmt_valid,
	output logic               fmt_ready,
	input  pfs_in_t            fmt,
	output logic               res_valid,
	input  logic               res_ready,
	output pfs_out_t           res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_PRE  = 2'd2;
	localparam logic [1:0] S_POP  = 2'd3;

	pfs_cfg_t    cfg;
	digit_ctrl_t dctrl;
	digit_stat_t dstat;

	logic [1:0]  state_q, state_d;
	logic        pend_q, pend_d;
	logic [31:0] count_q;
	logic        pre_v_q, pre_v_d;
	logic [7:0]  pre_q, pre_d;
	logic        dig_q, dig_d;
	logic        res_valid_q;
	pfs_out_t    res_q;
	pfs_out_t    item;
	logic        emit_ok;
	logic        accept;
	logic        emit;
	logic        em_term;
	logic        em_last;
	logic [7:0]  em_ch;
	logic [31:0] size_m1;

	pfs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pfs_digit #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_digit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (dctrl),
		.stat   (dstat)
	);

	assign emit_ok = !res_valid_q || res_ready;
	assign fmt_ready = (state_q == S_IDLE) && emit_ok;
	assign accept = fmt_valid && fmt_ready;
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_comb begin
		state_d = state_q;
		pend_d = pend_q;
		pre_v_d = pre_v_q;
		pre_d = pre_q;
		dig_d = dig_q;
		emit = 1'b0;
		em_term = 1'b0;
		em_last = 1'b1;
		em_ch = fmt.fmt_byte;
		dctrl = '0;
		dctrl.value = fmt.arg_value;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (fmt.fmt_byte == CH_NUL) begin
						emit = 1'b1;
						em_term = 1'b1;
						em_ch = CH_NUL;
						pend_d = 1'b0;
					end else if (!pend_q) begin
						if (fmt.fmt_byte == CH_PCT) begin
							pend_d = 1'b1;
						end else begin
							emit = 1'b1;
						end
					end else begin
						pend_d = 1'b0;
						unique case (fmt.fmt_byte)
							CH_PCT: begin
								emit = 1'b1;
							end
							CH_C: begin
								emit = 1'b1;
								em_ch = fmt.arg_value[7:0];
							end
							CH_D: begin
								dctrl.start = 1'b1;
								if (fmt.arg_value[31]) begin
									dctrl.value = 32'd0 - fmt.arg_value;
									emit = 1'b1;
									em_ch = CH_MINUS;
									em_last = 1'b0;
								end
								pre_v_d = 1'b0;
								dig_d = 1'b1;
								state_d = S_DIV;
							end
							CH_U: begin
								dctrl.start = 1'b1;
								pre_v_d = 1'b0;
								dig_d = 1'b1;
								state_d = S_DIV;
							end
							CH_X, CH_UX: begin
								dctrl.start = 1'b1;
								dctrl.hex = 1'b1;
								dctrl.upper = fmt.fmt_byte == CH_UX;
								pre_v_d = 1'b0;
								dig_d = 1'b1;
								state_d = S_DIV;
							end
							CH_P: begin
								dctrl.start = 1'b1;
								dctrl.hex = 1'b1;
								emit = 1'b1;
								em_ch = CH_ZERO;
								em_last = 1'b0;
								pre_v_d = 1'b1;
								pre_d = CH_X;
								dig_d = 1'b1;
								state_d = S_DIV;
							end
							default: begin
								emit = 1'b1;
								em_ch = CH_PCT;
								em_last = 1'b0;
								pre_v_d = 1'b1;
								pre_d = fmt.fmt_byte;
								dig_d = 1'b0;
								state_d = S_PRE;
							end
						endcase
					end
				end
			end
			S_DIV: begin
				if (!dstat.busy) begin
					state_d = S_PRE;
				end
			end
			S_PRE: begin
				if (!pre_v_q) begin
					state_d = S_POP;
				end else if (emit_ok) begin
					emit = 1'b1;
					em_ch = pre_q;
					em_last = !dig_q;
					pre_v_d = 1'b0;
					state_d = dig_q ? S_POP : S_IDLE;
				end
			end
			S_POP: begin
				if (emit_ok) begin
					emit = 1'b1;
					em_ch = dstat.digit;
					em_last = dstat.one;
					dctrl.pop = 1'b1;
					if (dstat.one) begin
						state_d = S_IDLE;
					end
				end
			end
		endcase
	end

	always_comb begin
		size_m1 = cfg.size - 32'd1;
		item.out_byte = em_ch;
		item.last = em_last;
		item.is_terminator = em_term;
		if (em_term) begin
			if (cfg.size == 32'd0) begin
				item.position = 32'd0;
			end else begin
				item.position = (count_q < size_m1) ? count_q : size_m1;
			end
			item.stored = cfg.present && (cfg.size != 32'd0);
			item.total_length = count_q;
		end else begin
			item.position = count_q;
			item.stored = cfg.present && (({1'b0, count_q} + 33'd1) < {1'b0, cfg.size});
			item.total_length = 32'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= item;
		end
		pre_q <= pre_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q <= 1'b0;
			count_q <= 32'd0;
			pre_v_q <= 1'b0;
			dig_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q <= pend_d;
			pre_v_q <= pre_v_d;
			dig_q <= dig_d;
			if (emit) begin
				res_valid_q <= 1'b1;
				count_q <= em_term ? 32'd0 : count_q + 32'd1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule
